>>> rtl/core/cdn_pkg.sv
package cdn_pkg;

  // Operation select codes
  localparam logic [2:0] FN_DATE_TO_ABS = 3'd0;
  localparam logic [2:0] FN_ABS_TO_DATE = 3'd1;
  localparam logic [2:0] FN_YEAR_DAY    = 3'd2;
  localparam logic [2:0] FN_MONTH_LEN   = 3'd3;
  localparam logic [2:0] FN_YDAY_TO_DM  = 3'd4;

  // Last supported absolute day: 29 February 10000
  localparam logic [21:0] MAX_ABS = 22'd3652424;

  localparam logic [21:0] DAYS_PER_400Y = 22'd146097;
  localparam logic [17:0] DAYS_PER_100Y = 18'd36524;
  localparam logic [21:0] DAYS_PER_4Y   = 22'd1461;
  localparam logic [11:0] DAYS_PER_Y    = 12'd365;

  // floor(2^24 / 1461), quotient estimate is exact or one low
  localparam logic [35:0] RECIP_4Y = 36'd11483;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] abs_day;
    logic [8:0]  day_of_year;
  } cdn_in_t;

  typedef struct packed {
    logic [21:0] abs_day_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [8:0]  year_day_out;
    logic [4:0]  month_length;
    logic        out_of_range;
  } cdn_out_t;

  // x / 100 for x below 25600, by reciprocal multiply
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    n = 5'd31;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      n = 5'd30;
    end else if (m == 4'd2) begin
      n = leap ? 5'd29 : 5'd28;
    end
    return n;
  endfunction

  // (489 * m) / 16
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd30;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd91;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd152;
      4'd6:    n = 9'd183;
      4'd7:    n = 9'd213;
      4'd8:    n = 9'd244;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd305;
      4'd11:   n = 9'd336;
      4'd12:   n = 9'd366;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/cdn_if.sv
interface cdn_in_if import cdn_pkg::*; ();
  logic    valid;
  logic    ready;
  cdn_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdn_out_if import cdn_pkg::*; ();
  logic     valid;
  logic     ready;
  cdn_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/cdn_split.sv
// Day offset from 1 March (0..365) to day of month and month.
module cdn_split (
  input  logic [8:0] id,
  output logic [4:0] day,
  output logic [3:0] month
);

  logic [9:0]  a;
  logic [12:0] ge;
  logic [3:0]  b;
  logic [9:0]  rem;
  logic [3:0]  bm;

  always_comb begin
    // Pad every 153-day block by 30 days so months fall on steps of 30.5
    if (id >= 9'd306) begin
      a = {id, 1'b0} + 10'd120;
    end else if (id >= 9'd153) begin
      a = {id, 1'b0} + 10'd60;
    end else begin
      a = {id, 1'b0};
    end
    for (int j = 0; j < 13; j++) begin
      ge[j] = a >= 10'(61 * (j + 1));
    end
    b   = 4'($countones(ge));
    rem = a - 10'(b) * 10'd61;
    day = 5'(rem[5:1]) + 5'd1;
    if (b >= 4'd12) begin
      bm = b - 4'd2 + 4'd2;
    end else if (b >= 4'd6) begin
      bm = b - 4'd1 + 4'd2;
    end else begin
      bm = b + 4'd2;
    end
    if (bm >= 4'd12) begin
      bm = bm - 4'd12;
    end
    month = bm + 4'd1;
  end

endmodule

>>> rtl/core/calendar_day_number_convert.sv
// Proleptic Gregorian converter, day 0 = 1 March of year 0. Eight register
// stages, the last being the output register; one beat is taken every cycle
// while out_ch.ready is high. Each stage has its own valid bit and advances
// when it is empty or the stage after it moves, so a stall at the output
// fills the bubbles first and in_ch.ready drops only when all eight stages
// hold data. The divides by 146097, 36524, 365 and 61 are done by parallel
// threshold compares, by 100 and 1461 by reciprocal multiplies, the latter
// with a one-step correction in its own stage.
module calendar_day_number_convert import cdn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cdn_in_if.sink    in_ch,
  cdn_out_if.source out_ch
);

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        b;
    logic        month_ok;
    logic [21:0] ad;
    logic        ad_bad;
    logic [4:0]  q400;
    logic [8:0]  rd;
    logic [7:0]  qa;
    logic [7:0]  qy;
    logic [7:0]  q100;
  } s1_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        month_ok;
    logic        day_ok;
    logic [4:0]  mlen;
    logic [23:0] abs_pos;
    logic [8:0]  abs_neg;
    logic [8:0]  yday;
    logic [21:0] ad;
    logic        ad_bad;
    logic [4:0]  q400;
    logic [17:0] r400;
    logic        rd_ok;
    logic [8:0]  yday_idx;
  } s2_t;

  typedef struct packed {
    logic [2:0]  func;
    cdn_out_t    res;
    logic [8:0]  yday_idx;
    logic [21:0] d1;
    logic [11:0] q;
    logic [11:0] r;
    logic [8:0]  id;
    logic [13:0] yr;
  } work_t;

  logic [7:0] vld_r;
  logic [7:0] adv;

  s1_t      s1_r, s1_nxt;
  s2_t      s2_r, s2_nxt;
  work_t    w3_r, w3_nxt;
  work_t    w4_r, w4_nxt;
  work_t    w5_r, w5_nxt;
  work_t    w6_r, w6_nxt;
  work_t    w7_r, w7_nxt;
  cdn_out_t out_r, out_nxt;

  logic [4:0]  split_day;
  logic [3:0]  split_month;

  // Stage control
  always_comb begin
    adv[7] = !vld_r[7] || out_ch.ready;
    adv[6] = !vld_r[6] || adv[7];
    adv[5] = !vld_r[5] || adv[6];
    adv[4] = !vld_r[4] || adv[5];
    adv[3] = !vld_r[3] || adv[4];
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign in_ch.ready  = adv[0];
  assign out_ch.valid = vld_r[7];
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_r & ~adv) | (adv & {vld_r[6:0], in_ch.valid});
    end
  end

  // Stage 1: quotients by 100 and by 146097
  always_comb begin
    logic [23:0] ge400;
    s1_nxt.func     = in_ch.data.func;
    s1_nxt.day      = in_ch.data.day;
    s1_nxt.month    = in_ch.data.month;
    s1_nxt.year     = in_ch.data.year;
    s1_nxt.b        = in_ch.data.month >= 4'd3;
    s1_nxt.month_ok = (in_ch.data.month != 4'd0) && (in_ch.data.month <= 4'd12);
    s1_nxt.ad       = in_ch.data.abs_day;
    s1_nxt.ad_bad   = in_ch.data.abs_day > MAX_ABS;
    s1_nxt.rd       = in_ch.data.day_of_year;
    for (int k = 0; k < 24; k++) begin
      ge400[k] = in_ch.data.abs_day >= 22'((k + 1) * 146097);
    end
    s1_nxt.q400 = 5'($countones(ge400));
    s1_nxt.qa   = div100({1'b0, in_ch.data.year} + {14'b0, s1_nxt.b} + 15'd99);
    s1_nxt.qy   = div100({1'b0, in_ch.data.year} + 15'd99);
    s1_nxt.q100 = div100({1'b0, in_ch.data.year});
  end

  // Stage 2: leap year, month length, day number terms, era remainder
  always_comb begin
    logic        leap;
    logic        nd4;
    logic [8:0]  c489;
    logic [9:0]  t_a;
    logic [9:0]  t_y;
    logic [9:0]  pos2;
    logic [9:0]  neg2;
    logic [8:0]  ylen;
    logic [9:0]  idx;
    nd4  = s1_r.year[1:0] != 2'b00;
    leap = !nd4 && ((s1_r.year != 14'(s1_r.q100) * 14'd100) || (s1_r.q100[1:0] == 2'b00));
    c489 = month_offset(s1_r.month);
    t_a  = {2'b0, s1_r.qa} + {1'b0, s1_r.qa, 1'b0};
    t_y  = {2'b0, s1_r.qy} + {1'b0, s1_r.qy, 1'b0};

    s2_nxt.func     = s1_r.func;
    s2_nxt.month_ok = s1_r.month_ok;
    s2_nxt.mlen     = month_days(s1_r.month, leap);
    s2_nxt.day_ok   = (s1_r.day != 5'd0) && (s1_r.day <= s2_nxt.mlen);

    s2_nxt.abs_pos = 24'(s1_r.year) * 24'd365 + 24'(s1_r.day)
                   + 24'(({1'b0, s1_r.year} + {14'b0, s1_r.b} + 15'd3) >> 2)
                   + 24'(c489);
    s2_nxt.abs_neg = {7'b0, s1_r.b, 1'b0} + 9'(t_a >> 2) + 9'd91;

    pos2 = {5'b0, s1_r.day} + {1'b0, c489} + (t_y >> 2);
    neg2 = (s1_r.b ? (nd4 ? 10'd2 : 10'd1) : 10'd0) + (t_a >> 2) + 10'd30;
    s2_nxt.yday = 9'(pos2 - neg2);

    ylen         = leap ? 9'd366 : 9'd365;
    s2_nxt.rd_ok = (s1_r.rd != 9'd0) && (s1_r.rd <= ylen);
    idx          = {1'b0, s1_r.rd} + 10'd305;
    if (idx >= {1'b0, ylen}) begin
      idx = idx - {1'b0, ylen};
    end
    s2_nxt.yday_idx = idx[8:0];

    s2_nxt.ad     = s1_r.ad;
    s2_nxt.ad_bad = s1_r.ad_bad;
    s2_nxt.q400   = s1_r.q400;
    s2_nxt.r400   = 18'(s1_r.ad - 22'(s1_r.q400) * DAYS_PER_400Y);
  end

  // Stage 3: range checks, finished fields, shifted day count
  always_comb begin
    logic [3:0]  ge100;
    logic [2:0]  q1;
    logic [23:0] n;
    logic        bad;
    n   = s2_r.abs_pos - 24'(s2_r.abs_neg);
    bad = 1'b0;
    w3_nxt          = '0;
    w3_nxt.func     = s2_r.func;
    w3_nxt.yday_idx = s2_r.yday_idx;
    case (s2_r.func)
      FN_DATE_TO_ABS: begin
        bad = !s2_r.month_ok || !s2_r.day_ok || (s2_r.abs_pos < 24'(s2_r.abs_neg))
              || (n > 24'(MAX_ABS));
        w3_nxt.res.abs_day_out = n[21:0];
      end
      FN_ABS_TO_DATE: bad = s2_r.ad_bad;
      FN_YEAR_DAY: begin
        bad = !s2_r.month_ok || !s2_r.day_ok;
        w3_nxt.res.year_day_out = s2_r.yday;
      end
      FN_MONTH_LEN: begin
        bad = !s2_r.month_ok;
        w3_nxt.res.month_length = s2_r.mlen;
      end
      FN_YDAY_TO_DM: bad = !s2_r.rd_ok;
      default:       bad = 1'b1;
    endcase
    if (bad) begin
      w3_nxt.res              = '0;
      w3_nxt.res.out_of_range = 1'b1;
    end

    for (int k = 0; k < 4; k++) begin
      ge100[k] = s2_r.r400 >= 18'((k + 1) * DAYS_PER_100Y);
    end
    q1 = 3'($countones(ge100));
    // Drop the fourth century step: it lands on the leap day of year 400
    w3_nxt.d1 = s2_r.ad + {16'b0, s2_r.q400, 1'b0} + {17'b0, s2_r.q400} + {19'b0, q1}
              - {21'b0, q1 == 3'd4};
  end

  // Stage 4: estimate d1 / 1461
  always_comb begin
    logic [35:0] prod;
    w4_nxt   = w3_r;
    prod     = 36'(w3_r.d1) * RECIP_4Y;
    w4_nxt.q = prod[35:24];
  end

  // Stage 5: remainder against the estimate
  always_comb begin
    logic [21:0] rr;
    w5_nxt   = w4_r;
    rr       = w4_r.d1 - 22'(w4_r.q) * DAYS_PER_4Y;
    w5_nxt.r = rr[11:0];
  end

  // Stage 6: correct an estimate that came out one low
  always_comb begin
    w6_nxt = w5_r;
    if (w5_r.r >= 12'(DAYS_PER_4Y)) begin
      w6_nxt.q = w5_r.q + 12'd1;
      w6_nxt.r = w5_r.r - 12'(DAYS_PER_4Y);
    end
  end

  // Stage 7: year within the 4-year block and day since 1 March
  always_comb begin
    logic [3:0] ge1;
    logic [2:0] q2;
    logic [1:0] q2p;
    w7_nxt = w6_r;
    for (int k = 0; k < 4; k++) begin
      ge1[k] = w6_r.r >= 12'((k + 1) * 365);
    end
    q2        = 3'($countones(ge1));
    q2p       = (q2 == 3'd4) ? 2'd3 : q2[1:0];
    w7_nxt.yr = {w6_r.q, 2'b00} + {12'b0, q2p};
    if (w6_r.func == FN_YDAY_TO_DM) begin
      w7_nxt.id = w6_r.yday_idx;
    end else begin
      w7_nxt.id = 9'(w6_r.r - 12'(q2p) * DAYS_PER_Y);
    end
  end

  cdn_split u_split (
    .id    (w7_r.id),
    .day   (split_day),
    .month (split_month)
  );

  // Stage 8: output register
  always_comb begin
    out_nxt = w7_r.res;
    if (!w7_r.res.out_of_range) begin
      if (w7_r.func == FN_ABS_TO_DATE) begin
        out_nxt.day_out   = split_day;
        out_nxt.month_out = split_month;
        // Jan and Feb belong to the next calendar year
        out_nxt.year_out  = w7_r.yr + {13'b0, w7_r.id >= 9'd306};
      end else if (w7_r.func == FN_YDAY_TO_DM) begin
        out_nxt.day_out   = split_day;
        out_nxt.month_out = split_month;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s1_r  <= s1_nxt;
    if (adv[1]) s2_r  <= s2_nxt;
    if (adv[2]) w3_r  <= w3_nxt;
    if (adv[3]) w4_r  <= w4_nxt;
    if (adv[4]) w5_r  <= w5_nxt;
    if (adv[5]) w6_r  <= w6_nxt;
    if (adv[6]) w7_r  <= w7_nxt;
    if (adv[7]) out_r <= out_nxt;
  end

endmodule
